// ----- src/anpc_pkg.sv -----
// Shared constants, types and helper functions for the authentication nonce pair collector.
package anpc_pkg;

    // Authenticate command codes carried in frame byte 0.
    localparam logic [7:0] CMD_KEY_A = 8'h60;
    localparam logic [7:0] CMD_KEY_B = 8'h61;

    // Frame lengths that the exchange expects.
    localparam logic [5:0] LEN_TAG_NONCE = 6'd4;
    localparam logic [5:0] LEN_READER_ANSWER = 6'd8;

    // Matcher phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMD_SEEN = 2'd1;
    localparam logic [1:0] PH_NONCE_SEEN = 2'd2;

    // Field widths.
    localparam int SECTOR_W = 6;
    localparam int LEN_W = 6;
    localparam int WORD_W = 32;

    // One captured triple as held in a slot.
    typedef struct packed {
        logic [WORD_W-1:0] tag_nonce;
        logic [WORD_W-1:0] reader_nonce;
        logic [WORD_W-1:0] reader_answer;
    } t_capture;

    localparam int CAPTURE_W = $bits(t_capture);

    // Map a block number to its sector: four blocks per sector below block 128,
    // sixteen blocks per sector from block 128 on.
    function automatic logic [SECTOR_W-1:0] block_to_sector(input logic [7:0] block);
        logic [SECTOR_W-1:0] sec;
        if (block[7]) begin
            sec = SECTOR_W'(6'd32 + {3'd0, block[6:4]});
        end else begin
            sec = {1'b0, block[6:2]};
        end
        return sec;
    endfunction

endpackage

// ----- src/anpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module anpc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 80,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered; reads return the old data on a collision.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/auth_nonce_pair_collector.sv -----
// Top level of the authentication nonce pair collector.
//
// Usage: sniffed contactless frames enter one per beat on the s_ stream.
// s_tuser carries the direction (1 = reader to tag) and s_tdata carries the
// raw length and the first eight frame bytes. The block follows the
// authenticate command, the tag nonce and the reader answer; each complete
// triple is kept in a slot per sector and key. When a second triple arrives
// for an occupied slot, one record with both captures leaves on the m_
// stream and the slot is freed. The card identifier is written over the
// APB port at address 0 while the block is idle; the block itself does not
// enforce this, so the user must. A frame that does not complete a triple
// leaves s_tready high; one that completes it moves the controller to the lookup
// state, with s_tready low, as the single slot RAM is read at the accept edge and
// written back or released there; a record built there is offered on m_tvalid.
// A finished record waits in the output register while further frames are
// taken; only a completing frame that pairs with a held capture and finds the
// output still full keeps s_tready low until the receiver takes the earlier record.
// Reset clears the matcher and all slot valid flags at once; the nonce RAM
// itself needs no clearing pass.
module auth_nonce_pair_collector
    import anpc_pkg::*;
#(
    parameter int NUM_SECTORS = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input frame stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: frame_len [5:0], head_word [37:6], tail_word [69:38], zero pad [71:70]
    input  logic [71:0]  s_tdata,
    // s_tuser: from_reader [0]
    input  logic         s_tuser,
    // Output record stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: sector [5:0], uid_out [37:6], tag_nonce_first [69:38],
    // reader_nonce_first [101:70], reader_answer_first [133:102],
    // tag_nonce_second [165:134], reader_nonce_second [197:166],
    // reader_answer_second [229:198], zero pad [231:230]
    output logic [231:0] m_tdata,
    // m_tuser: key_is_b [0]
    output logic         m_tuser,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SLOTS = 2 * NUM_SECTORS;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [SECTOR_W-1:0] SECTOR_LIMIT = SECTOR_W'(NUM_SECTORS);

    // Controller states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    // Configuration register index.
    localparam logic REG_CARD_UID = 1'b0;

    logic                 r_state, n_state;
    logic [1:0]           r_phase, n_phase;
    logic                 r_pend_key_b, n_pend_key_b;
    logic [SECTOR_W-1:0]  r_pend_sector, n_pend_sector;
    logic [WORD_W-1:0]    r_pend_tag_nonce, n_pend_tag_nonce;
    logic [WORD_W-1:0]    r_ans_nonce, n_ans_nonce;
    logic [WORD_W-1:0]    r_ans_answer, n_ans_answer;
    logic [SLOTS-1:0]     r_slot_valid, n_slot_valid;
    logic [WORD_W-1:0]    r_card_uid;

    logic                 r_out_valid, n_out_valid;
    logic [229:0]         r_out_data, n_out_data;
    logic                 r_out_key_b, n_out_key_b;

    logic                 in_beat;
    logic                 in_dir;
    logic [LEN_W-1:0]     in_len;
    logic [WORD_W-1:0]    in_head;
    logic [WORD_W-1:0]    in_tail;
    logic [7:0]           in_b0;
    logic [SECTOR_W-1:0]  in_sector;

    logic [SECTOR_W:0]    slot_idx_full;
    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_hit;
    logic                 out_free;
    logic                 ram_we;
    t_capture             ram_wdata;
    t_capture             ram_rdata;

    // Unpack the input beat.
    assign in_beat = s_tvalid && s_tready;
    assign in_dir = s_tuser;
    assign in_len = s_tdata[5:0];
    assign in_head = s_tdata[37:6];
    assign in_tail = s_tdata[69:38];
    assign in_b0 = in_head[31:24];
    assign in_sector = block_to_sector(in_head[23:16]);

    // Slot address follows the pending sector and key; the sector is always in range.
    assign slot_idx_full = {r_pend_sector, r_pend_key_b};
    assign slot_idx = slot_idx_full[IDX_W-1:0];
    assign slot_hit = r_slot_valid[slot_idx];
    assign out_free = !r_out_valid || m_tready;

    assign s_tready = (r_state == ST_IDLE);

    // Write back a first capture when the slot was empty.
    assign ram_we = (r_state == ST_LOOKUP) && !slot_hit;
    assign ram_wdata = '{tag_nonce: r_pend_tag_nonce, reader_nonce: r_ans_nonce,
                         reader_answer: r_ans_answer};

    anpc_ram #(
        .WIDTH (CAPTURE_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_idx),
        .i_wdata (ram_wdata),
        .i_raddr (slot_idx),
        .o_rdata (ram_rdata)
    );

    // Matcher, slot update and output register.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_pend_key_b = r_pend_key_b;
        n_pend_sector = r_pend_sector;
        n_pend_tag_nonce = r_pend_tag_nonce;
        n_ans_nonce = r_ans_nonce;
        n_ans_answer = r_ans_answer;
        n_slot_valid = r_slot_valid;
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;
        n_out_key_b = r_out_key_b;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_phase = PH_IDLE;
                    unique case (r_phase)
                        PH_IDLE: begin
                            if (in_dir && (in_b0 == CMD_KEY_A || in_b0 == CMD_KEY_B)
                                    && in_sector < SECTOR_LIMIT) begin
                                n_pend_key_b = (in_b0 == CMD_KEY_B);
                                n_pend_sector = in_sector;
                                n_phase = PH_CMD_SEEN;
                            end
                        end
                        PH_CMD_SEEN: begin
                            if (!in_dir && in_len == LEN_TAG_NONCE) begin
                                n_pend_tag_nonce = in_head;
                                n_phase = PH_NONCE_SEEN;
                            end
                        end
                        PH_NONCE_SEEN: begin
                            if (in_dir && in_len == LEN_READER_ANSWER) begin
                                n_ans_nonce = in_head;
                                n_ans_answer = in_tail;
                                n_state = ST_LOOKUP;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                // Slot data arrived from the RAM read issued at the accept edge.
                if (!slot_hit) begin
                    n_slot_valid[slot_idx] = 1'b1;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_slot_valid[slot_idx] = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_key_b = r_pend_key_b;
                    n_out_data = {r_ans_answer, r_ans_nonce, r_pend_tag_nonce,
                                  ram_rdata.reader_answer, ram_rdata.reader_nonce,
                                  ram_rdata.tag_nonce, r_card_uid, r_pend_sector};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_IDLE;
            r_slot_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_slot_valid <= n_slot_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Pending exchange; reset to zero like the matcher state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_key_b <= 1'b0;
            r_pend_sector <= '0;
            r_pend_tag_nonce <= '0;
        end else begin
            r_pend_key_b <= n_pend_key_b;
            r_pend_sector <= n_pend_sector;
            r_pend_tag_nonce <= n_pend_tag_nonce;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ans_nonce <= n_ans_nonce;
        r_ans_answer <= n_ans_answer;
        r_out_data <= n_out_data;
        r_out_key_b <= n_out_key_b;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_uid <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CARD_UID) begin
            r_card_uid <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CARD_UID) ? r_card_uid : 32'd0;

    assign m_tvalid = r_out_valid;
    assign m_tdata = {2'b00, r_out_data};
    assign m_tuser = r_out_key_b;

    // A record only ever appears after a slot lookup.
    a_record_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state) == ST_LOOKUP)
        else $error("record emitted without a slot lookup");

    // A pair that is emitted frees its slot.
    a_slot_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP && slot_hit && out_free) |=> !r_slot_valid[$past(slot_idx)])
        else $error("slot still valid after its pair was emitted");

    // At most one slot changes occupancy per cycle.
    a_one_slot_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid ^ $past(r_slot_valid)) <= 1)
        else $error("more than one slot changed in a cycle");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the authentication nonce pair collector.
module testbench
    import anpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SECTOR_LIMIT = 40;
    localparam int SLOT_TOTAL = 2 * SECTOR_LIMIT;
    localparam int REG_CARD_UID = 0;
    localparam logic [2:0] ADDR_CARD_UID = 3'(4 * REG_CARD_UID);
    localparam int QUIET_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    // One sniffed frame as it enters the block.
    typedef struct packed {
        logic        from_reader;
        logic [5:0]  frame_len;
        logic [31:0] head_word;
        logic [31:0] tail_word;
    } t_frame;

    // One record of two captures for the same sector and key.
    typedef struct packed {
        logic [5:0]  sector;
        logic        key_is_b;
        logic [31:0] uid;
        t_capture    first;
        t_capture    second;
    } t_nonce_pair;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [231:0] m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the matcher, the slots and the card identifier.
    logic [1:0]   match_phase = PH_IDLE;
    logic         held_key_b = 1'b0;
    int           held_sector = 0;
    logic [31:0]  held_tag_nonce = '0;
    logic         slot_full [SLOT_TOTAL];
    t_capture     slot_store [SLOT_TOTAL];
    logic [31:0]  card_uid_copy = '0;

    t_nonce_pair  nonce_pair_records [$];

    int frames_sent = 0;
    int records_checked = 0;
    int uid_settings = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    int hold_left = 0;

    string field_names [9] = '{"sector", "key_is_b", "uid_out", "tag_nonce_first",
                               "reader_nonce_first", "reader_answer_first",
                               "tag_nonce_second", "reader_nonce_second",
                               "reader_answer_second"};

    auth_nonce_pair_collector #(
        .NUM_SECTORS(SECTOR_LIMIT)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #400_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Follows the three-frame exchange and works out the record, if any, that a frame causes.
    function automatic void track_exchange(input t_frame f);
        logic [7:0] cmd_byte;
        logic [1:0] next_phase;
        t_nonce_pair rec;
        int blk;
        int sec;
        int slot;
        cmd_byte = f.head_word[31:24];
        blk = int'(f.head_word[23:16]);
        next_phase = PH_IDLE;
        frames_sent++;
        case (match_phase)
            PH_IDLE: begin
                if (f.from_reader && (cmd_byte == CMD_KEY_A || cmd_byte == CMD_KEY_B)) begin
                    sec = (blk < 128) ? blk / 4 : 32 + (blk - 128) / 16;
                    if (sec < SECTOR_LIMIT) begin
                        held_key_b = (cmd_byte == CMD_KEY_B);
                        held_sector = sec;
                        next_phase = PH_CMD_SEEN;
                    end
                end
            end
            PH_CMD_SEEN: begin
                if (!f.from_reader && f.frame_len == LEN_TAG_NONCE) begin
                    held_tag_nonce = f.head_word;
                    next_phase = PH_NONCE_SEEN;
                end
            end
            PH_NONCE_SEEN: begin
                if (f.from_reader && f.frame_len == LEN_READER_ANSWER) begin
                    slot = held_sector * 2 + int'(held_key_b);
                    if (slot_full[slot]) begin
                        rec.sector = 6'(held_sector);
                        rec.key_is_b = held_key_b;
                        rec.uid = card_uid_copy;
                        rec.first = slot_store[slot];
                        rec.second = '{tag_nonce: held_tag_nonce, reader_nonce: f.head_word,
                                       reader_answer: f.tail_word};
                        nonce_pair_records.push_back(rec);
                        slot_full[slot] = 1'b0;
                    end else begin
                        slot_store[slot] = '{tag_nonce: held_tag_nonce,
                                             reader_nonce: f.head_word,
                                             reader_answer: f.tail_word};
                        slot_full[slot] = 1'b1;
                    end
                end
            end
            default: begin
                // The unused phase code behaves like an unmatched frame.
            end
        endcase
        match_phase = next_phase;
    endfunction

    function automatic t_frame make_frame(input logic dir, input logic [5:0] len,
                                          input logic [31:0] head, input logic [31:0] tail);
        t_frame f;
        f.from_reader = dir;
        f.frame_len = len;
        f.head_word = head;
        f.tail_word = tail;
        return f;
    endfunction

    // A frame of random content, now and then carrying an authenticate code.
    function automatic t_frame noise_frame();
        t_frame f;
        f = make_frame(1'($urandom_range(0, 1)), 6'($urandom_range(0, 32)), $urandom, $urandom);
        if ($urandom_range(0, 3) == 0) begin
            f.head_word[31:24] = $urandom_range(0, 1) ? CMD_KEY_B : CMD_KEY_A;
        end
        return f;
    endfunction

    // Sends one frame beat, with random gaps between bursts, and updates the shadow model.
    task automatic send_frame(input t_frame f);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_tvalid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tuser = f.from_reader;
        s_tdata = {2'b00, f.tail_word, f.head_word, f.frame_len};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        track_exchange(f);
    endtask

    // A full exchange: authenticate command, tag nonce and reader answer.
    task automatic send_exchange(input logic [7:0] cmd, input logic [7:0] blk,
                                 input logic [5:0] cmd_len, input logic [31:0] tag_nonce,
                                 input logic [31:0] reader_nonce, input logic [31:0] answer);
        send_frame(make_frame(1'b1, cmd_len, {cmd, blk, 16'($urandom)}, $urandom));
        send_frame(make_frame(1'b0, LEN_TAG_NONCE, tag_nonce, $urandom));
        send_frame(make_frame(1'b1, LEN_READER_ANSWER, reader_nonce, answer));
    endtask

    // Lets the block drain: no frame offered, every record in, then a spare quiet wait.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (nonce_pair_records.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_card_uid(input logic [31:0] uid);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_CARD_UID;
        pwdata = uid;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        card_uid_copy = uid;
        uid_settings++;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Receiver: stall pattern of its own, with a long hold-off on request.
    initial begin : receiver
        int pattern_left;
        int stall_mode;
        pattern_left = 0;
        stall_mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(8, 64);
                    stall_mode = $urandom_range(0, 3);
                end
                pattern_left--;
                case (stall_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 1) == 1);
                    2: m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compares each record beat with the oldest prediction, field by field.
    always @(posedge i_clk) begin : check_records
        logic [31:0] want [9];
        logic [31:0] got [9];
        t_nonce_pair rec;
        if (i_rst_n && m_tvalid && m_tready) begin
            records_checked++;
            if (nonce_pair_records.size() == 0) begin
                note_mismatch("record with none due", '0, 32'(m_tdata[5:0]));
            end else begin
                rec = nonce_pair_records.pop_front();
                want = '{32'(rec.sector), 32'(rec.key_is_b), rec.uid,
                         rec.first.tag_nonce, rec.first.reader_nonce,
                         rec.first.reader_answer, rec.second.tag_nonce,
                         rec.second.reader_nonce, rec.second.reader_answer};
                got = '{32'(m_tdata[5:0]), 32'(m_tuser), m_tdata[37:6], m_tdata[69:38],
                        m_tdata[101:70], m_tdata[133:102], m_tdata[165:134],
                        m_tdata[197:166], m_tdata[229:198]};
                for (int i = 0; i < 9; i++) begin
                    if (want[i] !== got[i]) begin
                        note_mismatch(field_names[i], want[i], got[i]);
                    end
                end
            end
        end
    end

    // Two captures on sector 0 with key A, at the low and high ends of the words.
    task automatic test_key_a_pair();
        send_exchange(CMD_KEY_A, 8'd0, 6'd4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_exchange(CMD_KEY_A, 8'd3, 6'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Key B on the topmost sector, with commands of zero and maximum length.
    task automatic test_key_b_top_sector();
        send_exchange(CMD_KEY_B, 8'd255, 6'd0, $urandom, $urandom, 32'hFFFF_FFFF);
        send_exchange(CMD_KEY_B, 8'd240, 6'd32, $urandom, $urandom, $urandom);
    endtask

    // Exchanges broken at each step; every one must drop the matcher back to idle.
    task automatic test_broken_exchanges();
        // A command sent by the tag is not a command.
        send_frame(make_frame(1'b0, 6'd4, {CMD_KEY_A, 8'd4, 16'h0}, 32'h0));
        // A second command in place of the nonce resets, and is not taken as a new command.
        send_frame(make_frame(1'b1, 6'd4, {CMD_KEY_B, 8'd127, 16'h0}, 32'h0));
        send_frame(make_frame(1'b1, 6'd4, {CMD_KEY_B, 8'd127, 16'h0}, 32'h0));
        send_frame(make_frame(1'b0, LEN_TAG_NONCE, $urandom, $urandom));
        send_frame(make_frame(1'b1, LEN_READER_ANSWER, $urandom, $urandom));
        // Tag nonce of the wrong length.
        send_frame(make_frame(1'b1, 6'd4, {CMD_KEY_A, 8'd128, 16'hFFFF}, 32'h0));
        send_frame(make_frame(1'b0, 6'd5, $urandom, $urandom));
        // Reader answer one byte short.
        send_frame(make_frame(1'b1, 6'd4, {CMD_KEY_A, 8'd128, 16'h0}, 32'h0));
        send_frame(make_frame(1'b0, LEN_TAG_NONCE, $urandom, $urandom));
        send_frame(make_frame(1'b1, 6'd7, $urandom, $urandom));
        // Answer of the right length but sent by the tag.
        send_frame(make_frame(1'b1, 6'd4, {CMD_KEY_B, 8'd128, 16'h0}, 32'h0));
        send_frame(make_frame(1'b0, LEN_TAG_NONCE, $urandom, $urandom));
        send_frame(make_frame(1'b0, LEN_READER_ANSWER, $urandom, $urandom));
    endtask

    // Mostly well-formed exchanges on a few hot blocks, with noise and broken exchanges.
    task automatic test_random_exchanges(input logic [31:0] uid, input int frame_goal);
        logic [7:0] hot_blocks [4];
        logic [7:0] blk;
        logic [7:0] cmd;
        t_frame trio [3];
        int sent;
        wait_quiet();
        write_card_uid(uid);
        foreach (hot_blocks[i]) hot_blocks[i] = 8'($urandom_range(0, 255));
        sent = 0;
        while (sent < frame_goal) begin
            if ($urandom_range(0, 3) == 0) begin
                send_frame(noise_frame());
                sent++;
            end else begin
                blk = ($urandom_range(0, 2) != 0) ? hot_blocks[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255));
                cmd = $urandom_range(0, 1) ? CMD_KEY_B : CMD_KEY_A;
                trio[0] = make_frame(1'b1,
                                     ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 32))
                                                                 : 6'd4,
                                     {cmd, blk, 16'($urandom)}, $urandom);
                trio[1] = make_frame(1'b0, LEN_TAG_NONCE, $urandom, $urandom);
                trio[2] = make_frame(1'b1, LEN_READER_ANSWER, $urandom, $urandom);
                if ($urandom_range(0, 9) == 0) begin
                    trio[$urandom_range(0, 2)] = noise_frame();
                end
                foreach (trio[i]) send_frame(trio[i]);
                sent += 3;
            end
        end
    endtask

    // The receiver holds off for a long stretch while completing exchanges keep coming.
    task automatic test_output_backpressure();
        wait_quiet();
        write_card_uid(32'h0000_0000);
        @(posedge i_clk);
        hold_left = LONG_HOLD_CYCLES;
        for (int i = 0; i < 10; i++) begin
            send_exchange(CMD_KEY_A, 8'(4 * i), 6'd4, $urandom, $urandom, $urandom);
            send_exchange(CMD_KEY_A, 8'(4 * i), 6'd4, $urandom, $urandom, $urandom);
        end
    endtask

    // Test sequence.
    initial begin
        foreach (slot_full[i]) slot_full[i] = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_key_a_pair();
        test_key_b_top_sector();
        test_broken_exchanges();
        test_random_exchanges(32'hFFFF_FFFF, 450);
        test_random_exchanges($urandom, 450);
        test_output_backpressure();
        test_random_exchanges(32'h0000_0000, 450);
        test_random_exchanges($urandom, 430);
        wait_quiet();

        $display("Covered %0d frames across %0d card identifier settings and %0d records,",
                 frames_sent, uid_settings, records_checked);
        $display("including broken exchanges and a %0d-cycle receiver hold-off.",
                 LONG_HOLD_CYCLES);
        if (mismatch_count == 0 && nonce_pair_records.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
